/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the trajectory generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define STG_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define STG_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/stg_pkg.sv */
// ----------------------------------------------------------------------------
// stg_pkg
// Types, constants and the division step function of the sinusoidal trajectory generator.
// ----------------------------------------------------------------------------
package stg_pkg;

	localparam int DATA_WIDTH_DEF  = 32;
	localparam int SINE_STAGES_DEF = 24;
	localparam int DIV_STEPS       = 64;
	localparam int MUL_LAT         = 3;
	localparam int ATAN_DEPTH      = 40;

	localparam logic signed [34:0] PI_Q30    = 35'sd3373259426;
	localparam logic signed [34:0] INVPI_Q32 = 35'sd1367130551;
	localparam logic signed [32:0] GAIN_Q30  = 33'sd652032874;

	localparam logic [29:0] ATAN_TAB [ATAN_DEPTH] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
		30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1,
		30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
	};

	typedef enum logic [2:0] {
		REG_DURATION  = 3'd0,
		REG_START_POS = 3'd1,
		REG_END_POS   = 3'd2,
		REG_START_VEL = 3'd3,
		REG_END_VEL   = 3'd4
	} stg_reg_e;

	typedef enum logic [2:0] {
		D_IDLE,
		D_MUL_DP,
		D_DIV,
		D_MUL_VS,
		D_MUL_K1,
		D_MUL_K,
		D_MUL_P1,
		D_MUL_AP
	} stg_dstate_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [63:0] dq;
	} stg_dstep_t;

	typedef struct packed {
		stg_dstep_t  st;
		logic [31:0] t;
	} stg_div_t;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [33:0] z;
		logic               flip;
		logic [31:0]        t;
		logic [62:0]        tau;
	} stg_rot_t;

	typedef struct packed {
		logic               busy;
		logic [31:0]        dur;
		logic signed [31:0] p0;
		logic signed [31:0] v0;
		logic signed [32:0] dv;
		logic signed [31:0] amp;
		logic [31:0]        inv;
		logic signed [61:0] k;
		logic signed [61:0] ap;
	} stg_coef_t;

	function automatic stg_dstep_t div_step(input stg_dstep_t s, input logic [31:0] d);
		logic [32:0] cand;
		logic [32:0] diff;
		logic        ge;
		stg_dstep_t  r;
		cand   = {s.rem, s.dq[63]};
		diff   = cand - {1'b0, d};
		ge     = cand >= {1'b0, d};
		r.rem  = ge ? diff[31:0] : cand[31:0];
		r.dq   = {s.dq[62:0], ge};
		return r;
	endfunction

endpackage

/* design/stg_in_if.sv */
// ----------------------------------------------------------------------------
// stg_in_if
// Time sample channel.
// ----------------------------------------------------------------------------
interface stg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_point;

	modport source (output valid, output time_point, input ready);
	modport sink (input valid, input time_point, output ready);
endinterface

/* design/stg_out_if.sv */
// ----------------------------------------------------------------------------
// stg_out_if
// Trajectory result channel.
// ----------------------------------------------------------------------------
interface stg_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic signed [31:0] acceleration;

	modport source (output valid, output position, output velocity, output acceleration,
		input ready);
	modport sink (input valid, input position, input velocity, input acceleration,
		output ready);
endinterface

/* design/sinusoidal_trajectory_generator.sv */
// ----------------------------------------------------------------------------
// sinusoidal_trajectory_generator
// Throughput: one beat per cycle; 64 divider cells, SINE_STAGES CORDIC cells and
// two three-stage multiplier levels, all advancing together, stall on output.
// Each valid register write recomputes the coefficients: ready is low in the
// write cycle and while the recompute runs.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sinusoidal_trajectory_generator import stg_pkg::*; #(
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
	parameter int SINE_STAGES = SINE_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	stg_in_if.sink      sample,
	stg_out_if.source   result
);

	localparam logic signed [63:0] OMAX  = $signed(64'hFFFF_FFFF_FFFF_FFFF >> (65 - DATA_WIDTH));
	localparam logic signed [63:0] OMIN  = -OMAX - 64'sd1;
	localparam logic [63:0]        OMASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - DATA_WIDTH);
	localparam logic signed [33:0] QTR   = 34'sd1 <<< 30;
	localparam logic signed [33:0] HALF  = 34'sd1 <<< 31;
	localparam logic [63:0]        TAU_MAX = 64'd1 << 62;

	stg_coef_t          coef;
	logic               adv, acc_in;
	logic [DIV_STEPS:0] div_v;
	stg_div_t           div_d [DIV_STEPS + 1];
	logic [SINE_STAGES:0] rot_v;
	stg_rot_t           rot_d [SINE_STAGES + 1];
	logic [63:0]        tau_u;
	logic signed [33:0] za, zr;
	logic               flip;
	stg_rot_t           fin;
	logic signed [33:0] csf, snf;
	logic signed [61:0] m_v0t, m_dt16, m_k, m_dt32, m_amp, m_dinv, m_ap, m_pos2;
	logic [5:0]         vld_q;
	logic [31:0]        t_s1, t_s2, t_s3;
	logic signed [63:0] pp, vel, acc;
	logic signed [63:0] pp_s4, pp_s5, pp_s6;
	logic [31:0]        vel_s4, vel_s5, vel_s6, acc_s4, acc_s5, acc_s6;
	logic               out_vld_q;
	logic [31:0]        pos_q, vel_q, acc_q;

	function automatic logic [31:0] sat_out(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = (v < OMIN) ? OMIN : ((v > OMAX) ? OMAX : v);
		return 32'(c & OMASK);
	endfunction

	stg_derive u_derive (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	assign adv          = !out_vld_q || result.ready;
	assign sample.ready = adv && !coef.busy && !cfg_wr_en;
	assign acc_in       = sample.valid && sample.ready;

	always_comb begin
		div_v[0]           = acc_in;
		div_d[0].st.rem    = '0;
		div_d[0].st.dq     = {sample.time_point, 32'b0};
		div_d[0].t         = sample.time_point;
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		stg_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.divisor  (coef.dur),
			.up_valid (div_v[i]),
			.up_data  (div_d[i]),
			.dn_valid (div_v[i + 1]),
			.dn_data  (div_d[i + 1])
		);
	end

	always_comb begin
		tau_u = div_d[DIV_STEPS].st.dq;
		za    = 34'($signed(tau_u[32:1]));
		flip  = 1'b0;
		zr    = za;
		if (za > QTR) begin
			zr   = za - HALF;
			flip = 1'b1;
		end else if (za < -QTR) begin
			zr   = za + HALF;
			flip = 1'b1;
		end
		rot_v[0]      = div_v[DIV_STEPS];
		rot_d[0].x    = GAIN_Q30;
		rot_d[0].y    = '0;
		rot_d[0].z    = zr;
		rot_d[0].flip = flip;
		rot_d[0].t    = div_d[DIV_STEPS].t;
		rot_d[0].tau  = (tau_u > TAU_MAX) ? TAU_MAX[62:0] : tau_u[62:0];
	end

	for (genvar j = 0; j < SINE_STAGES; j++) begin : g_rot
		stg_cordic_cell #(.STAGE(j)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.up_valid (rot_v[j]),
			.up_data  (rot_d[j]),
			.dn_valid (rot_v[j + 1]),
			.dn_data  (rot_d[j + 1])
		);
	end

	always_comb begin
		fin = rot_d[SINE_STAGES];
		csf = fin.flip ? -34'(fin.x) : 34'(fin.x);
		snf = fin.flip ? -34'(fin.y) : 34'(fin.y);
	end

	stg_mulsh u_v0t (.clk(clk), .en(adv), .a(64'(coef.v0)), .b($signed({3'b0, fin.t})),
		.sh(6'd16), .p(m_v0t));
	stg_mulsh u_dt16 (.clk(clk), .en(adv), .a($signed({1'b0, fin.tau})), .b(35'(coef.dv)),
		.sh(6'd16), .p(m_dt16));
	stg_mulsh u_k (.clk(clk), .en(adv), .a(64'(coef.k)), .b(35'(QTR) - 35'(csf)),
		.sh(6'd30), .p(m_k));
	stg_mulsh u_dt32 (.clk(clk), .en(adv), .a($signed({1'b0, fin.tau})), .b(35'(coef.dv)),
		.sh(6'd32), .p(m_dt32));
	stg_mulsh u_amp (.clk(clk), .en(adv), .a(64'(coef.amp)), .b(35'(snf)),
		.sh(6'd30), .p(m_amp));
	stg_mulsh u_dinv (.clk(clk), .en(adv), .a(64'(coef.dv)), .b($signed({3'b0, coef.inv})),
		.sh(6'd16), .p(m_dinv));
	stg_mulsh u_ap (.clk(clk), .en(adv), .a(64'(coef.ap)), .b(35'(csf)),
		.sh(6'd30), .p(m_ap));
	stg_mulsh u_pos2 (.clk(clk), .en(adv), .a(64'(m_dt16)), .b($signed({3'b0, t_s3})),
		.sh(6'd33), .p(m_pos2));

	always_comb begin
		pp  = 64'(coef.p0) + 64'(m_v0t) + 64'(m_k);
		vel = 64'(coef.v0) + 64'(m_dt32) + 64'(m_amp);
		acc = 64'(m_dinv) + 64'(m_ap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[4:0], rot_v[SINE_STAGES]};
			out_vld_q <= vld_q[5];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1   <= fin.t;
			t_s2   <= t_s1;
			t_s3   <= t_s2;
			pp_s4  <= pp;
			pp_s5  <= pp_s4;
			pp_s6  <= pp_s5;
			vel_s4 <= sat_out(vel);
			vel_s5 <= vel_s4;
			vel_s6 <= vel_s5;
			acc_s4 <= sat_out(acc);
			acc_s5 <= acc_s4;
			acc_s6 <= acc_s5;
			pos_q  <= sat_out(pp_s6 + 64'(m_pos2));
			vel_q  <= vel_s6;
			acc_q  <= acc_s6;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.position     = $signed(pos_q);
	assign result.velocity     = $signed(vel_q);
	assign result.acceleration = $signed(acc_q);

	`STG_ASSERT_IMP(a_busy_blocks_input, clk, arst_n, coef.busy, !sample.ready)
	`STG_ASSERT_NXT(a_write_starts_derive, clk, arst_n,
		cfg_wr_en && (cfg_index <= 3'(REG_END_VEL)), coef.busy)
	`STG_ASSERT_NXT(a_stall_freezes_pipe, clk, arst_n, result.valid && !result.ready,
		$stable(vld_q) && $stable(div_v[DIV_STEPS:1]) && $stable(rot_v))

endmodule

/* design/stg_mulsh.sv */
// ----------------------------------------------------------------------------
// stg_mulsh
// Three-stage signed multiply, shift toward zero and saturate at 2^60.
// ----------------------------------------------------------------------------
module stg_mulsh import stg_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] a,
	input  logic signed [34:0] b,
	input  logic [5:0]         sh,
	output logic signed [61:0] p
);

	localparam logic [98:0] LIM = 99'd1 << 60;

	logic [63:0]        ua;
	logic [34:0]        ub;
	logic               neg_s1, neg_s2;
	logic [5:0]         sh_s1, sh_s2;
	logic [66:0]        pl_s1, ph_s1;
	logic [98:0]        prod_s2;
	logic [98:0]        shv;
	logic [60:0]        mag;
	logic signed [61:0] p_s3;

	always_comb begin
		ua  = a[63] ? 64'(-a) : 64'(a);
		ub  = b[34] ? 35'(-b) : 35'(b);
		shv = prod_s2 >> sh_s2;
		mag = (shv > LIM) ? LIM[60:0] : shv[60:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= a[63] ^ b[34];
			sh_s1   <= sh;
			pl_s1   <= 67'(ua[31:0]) * 67'(ub);
			ph_s1   <= 67'(ua[63:32]) * 67'(ub);
			neg_s2  <= neg_s1;
			sh_s2   <= sh_s1;
			prod_s2 <= {ph_s1, 32'b0} + 99'(pl_s1);
			p_s3    <= neg_s2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign p = p_s3;

endmodule

/* design/stg_div_cell.sv */
// ----------------------------------------------------------------------------
// stg_div_cell
// One restoring-division step: one quotient bit of time_point * 2^32 / T.
// ----------------------------------------------------------------------------
module stg_div_cell import stg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [31:0] divisor,
	input  logic        up_valid,
	input  stg_div_t    up_data,
	output logic        dn_valid,
	output stg_div_t    dn_data
);

	logic     valid_q;
	stg_div_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.st <= div_step(up_data.st, divisor);
			data_q.t  <= up_data.t;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

/* design/stg_cordic_cell.sv */
// ----------------------------------------------------------------------------
// stg_cordic_cell
// One CORDIC rotation step towards zero residual angle.
// ----------------------------------------------------------------------------
module stg_cordic_cell import stg_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     up_valid,
	input  stg_rot_t up_data,
	output logic     dn_valid,
	output stg_rot_t dn_data
);

	logic               valid_q;
	stg_rot_t           data_q;
	stg_rot_t           nxt;
	logic signed [32:0] dx, dy;
	logic signed [33:0] at;

	always_comb begin
		dx  = up_data.y >>> STAGE;
		dy  = up_data.x >>> STAGE;
		at  = $signed({4'b0, ATAN_TAB[STAGE]});
		nxt = up_data;
		if (up_data.z >= 0) begin
			nxt.x = up_data.x - dx;
			nxt.y = up_data.y + dy;
			nxt.z = up_data.z - at;
		end else begin
			nxt.x = up_data.x + dx;
			nxt.y = up_data.y - dy;
			nxt.z = up_data.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

/* design/stg_derive.sv */
// ----------------------------------------------------------------------------
// stg_derive
// Register file and sequencer for amplitude, reciprocal and fixed products.
// ----------------------------------------------------------------------------
module stg_derive import stg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output stg_coef_t   coef
);

	stg_dstate_t        state_q, state_d;
	logic [5:0]         cnt_q;
	logic [31:0]        dur_q, dur;
	logic signed [31:0] sp_q, ep_q, sv_q, ev_q;
	logic signed [31:0] amp_q;
	logic [31:0]        inv_q;
	logic signed [61:0] k_q, ap_q, tmp_q;
	logic               n_neg_q;
	stg_dstep_t         sa_q, sb_q;
	logic               wr_ok, mul_done;
	logic signed [32:0] dp, vs;
	logic signed [63:0] mul_a, qs, diff, clamped;
	logic signed [34:0] mul_b;
	logic [5:0]         mul_sh;
	logic signed [61:0] mul_p;

	always_comb begin
		wr_ok    = cfg_wr_en && (cfg_index <= 3'(REG_END_VEL));
		mul_done = cnt_q == 6'(MUL_LAT);
		dur      = (dur_q == 32'd0) ? 32'd1 : dur_q;
		dp       = 33'(ep_q) - 33'(sp_q);
		vs       = 33'(ev_q) + 33'(sv_q);
		qs       = n_neg_q ? -$signed(sa_q.dq) : $signed(sa_q.dq);
		diff     = qs - 64'(mul_p);
		if (diff < -64'sd2147483648) begin
			clamped = -64'sd2147483648;
		end else if (diff > 64'sd2147483647) begin
			clamped = 64'sd2147483647;
		end else begin
			clamped = diff;
		end
	end

	always_comb begin
		state_d = state_q;
		if (wr_ok) begin
			state_d = D_MUL_DP;
		end else begin
			unique case (state_q)
				D_IDLE:   state_d = D_IDLE;
				D_MUL_DP: if (mul_done) state_d = D_DIV;
				D_DIV:    if (cnt_q == 6'(DIV_STEPS - 1)) state_d = D_MUL_VS;
				D_MUL_VS: if (mul_done) state_d = D_MUL_K1;
				D_MUL_K1: if (mul_done) state_d = D_MUL_K;
				D_MUL_K:  if (mul_done) state_d = D_MUL_P1;
				D_MUL_P1: if (mul_done) state_d = D_MUL_AP;
				D_MUL_AP: if (mul_done) state_d = D_IDLE;
				default:  state_d = D_IDLE;
			endcase
		end
	end

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_sh = '0;
		unique case (state_q)
			D_MUL_DP: begin
				mul_a  = 64'(dp);
				mul_b  = PI_Q30;
				mul_sh = 6'd15;
			end
			D_MUL_VS: begin
				mul_a  = 64'(vs);
				mul_b  = PI_Q30;
				mul_sh = 6'd32;
			end
			D_MUL_K1: begin
				mul_a  = 64'(amp_q);
				mul_b  = $signed({3'b0, dur});
				mul_sh = 6'd16;
			end
			D_MUL_K: begin
				mul_a  = 64'(tmp_q);
				mul_b  = INVPI_Q32;
				mul_sh = 6'd32;
			end
			D_MUL_P1: begin
				mul_a  = 64'(amp_q);
				mul_b  = PI_Q30;
				mul_sh = 6'd30;
			end
			D_MUL_AP: begin
				mul_a  = 64'(tmp_q);
				mul_b  = $signed({3'b0, inv_q});
				mul_sh = 6'd16;
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				mul_sh = '0;
			end
		endcase
	end

	stg_mulsh u_mul (
		.clk (clk),
		.en  (1'b1),
		.a   (mul_a),
		.b   (mul_b),
		.sh  (mul_sh),
		.p   (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			dur_q   <= 32'd65536;
			sp_q    <= '0;
			ep_q    <= '0;
			sv_q    <= '0;
			ev_q    <= '0;
			amp_q   <= '0;
			inv_q   <= '0;
			k_q     <= '0;
			ap_q    <= '0;
		end else begin
			state_q <= state_d;
			if (wr_ok || (state_d != state_q)) begin
				cnt_q <= '0;
			end else if (state_q != D_IDLE) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					3'(REG_DURATION):  dur_q <= cfg_data;
					3'(REG_START_POS): sp_q  <= $signed(cfg_data);
					3'(REG_END_POS):   ep_q  <= $signed(cfg_data);
					3'(REG_START_VEL): sv_q  <= $signed(cfg_data);
					3'(REG_END_VEL):   ev_q  <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (mul_done) begin
				unique case (state_q)
					D_MUL_VS: begin
						amp_q <= 32'(clamped);
						inv_q <= (sb_q.dq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sb_q.dq[31:0];
					end
					D_MUL_K:  k_q  <= mul_p;
					D_MUL_AP: ap_q <= mul_p;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_MUL_DP: begin
				if (mul_done) begin
					n_neg_q   <= mul_p < 0;
					sa_q.rem  <= '0;
					sa_q.dq   <= (mul_p < 0) ? 64'(-mul_p) : 64'(mul_p);
					sb_q.rem  <= '0;
					sb_q.dq   <= 64'h1_0000_0000;
				end
			end
			D_DIV: begin
				sa_q <= div_step(sa_q, dur);
				sb_q <= div_step(sb_q, dur);
			end
			D_MUL_K1, D_MUL_P1: begin
				if (mul_done) tmp_q <= mul_p;
			end
			default: ;
		endcase
	end

	always_comb begin
		coef.busy = state_q != D_IDLE;
		coef.dur  = dur;
		coef.p0   = sp_q;
		coef.v0   = sv_q;
		coef.dv   = 33'(ev_q) - 33'(sv_q);
		coef.amp  = amp_q;
		coef.inv  = inv_q;
		coef.k    = k_q;
		coef.ap   = ap_q;
	end

endmodule

/* tb/tb_sinusoidal_trajectory_generator.sv */
// ----------------------------------------------------------------------------
// tb_sinusoidal_trajectory_generator
// Self-checking bench for the sinusoidal trajectory generator. A bit-true
// predictor of the Q16.16 position, velocity and acceleration, with its own
// copy of the move registers, checks every result beat. Directed moves cover
// phase points, zero and tiny durations, saturation and ignored writes. Random
// moves then run under three idling patterns and a long output stall.
// ----------------------------------------------------------------------------
module tb_sinusoidal_trajectory_generator import stg_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          STAGES      = SINE_STAGES_DEF;
	localparam int          LATENCY     = 71 + STAGES;
	localparam longint      CYCLE_LIMIT = 600000;
	localparam longint      TERM_LIM    = 64'sd1 << 60;
	localparam logic [2:0]  REG_SPARE_LO = 3'd5;
	localparam logic [2:0]  REG_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic signed [31:0] acceleration;
	} motion_sample_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	stg_in_if  sample_if();
	stg_out_if result_if();

	sinusoidal_trajectory_generator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample_if),
		.result   (result_if)
	);

	logic [31:0] move_duration, start_position, end_position, start_velocity, end_velocity;
	longint      sine_amplitude;
	longint      inverse_duration;

	motion_sample_t pending_samples [$];
	int     mismatches;
	int     beats_sent;
	int     beats_checked;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     stall_request;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("sinusoidal_trajectory_generator: mismatch");
			$finish;
		end
	end

	// (a*b) >> sh, truncated toward zero, magnitude clamped at 2^60
	function automatic longint scaled_mul(input longint a, input longint b, input int sh);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] prod;
		logic [63:0]  mag;
		bit           neg;
		neg  = (a < 0) != (b < 0);
		ua   = a < 0 ? -a : a;
		ub   = b < 0 ? -b : b;
		prod = {64'd0, ua} * {64'd0, ub};
		if (sh > 63)
			sh = 63;
		prod = prod >> sh;
		mag  = (prod > 128'(TERM_LIM)) ? TERM_LIM : prod[63:0];
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic longint clamp32(input longint v);
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		return v;
	endfunction

	function automatic longint duration_lsb();
		return move_duration == 0 ? 64'd1 : longint'(move_duration);
	endfunction

	function automatic void derive_coefficients();
		longint dur;
		longint dp;
		longint vs;
		longint amp;
		logic [63:0] recip;
		dur   = duration_lsb();
		dp    = longint'($signed(end_position)) - longint'($signed(start_position));
		vs    = longint'($signed(end_velocity)) + longint'($signed(start_velocity));
		amp   = scaled_mul(dp, longint'(PI_Q30), 15) / dur - scaled_mul(vs, longint'(PI_Q30), 32);
		recip = (64'd1 << 32) / dur;
		sine_amplitude   = clamp32(amp);
		inverse_duration = recip > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : recip;
	endfunction

	function automatic motion_sample_t predict_motion(input logic [31:0] time_point);
		logic [63:0] t;
		logic [63:0] dur;
		logic [63:0] rem;
		logic [63:0] tau_u;
		longint ang, tau, x, y, dx, dy, k, p0, v0, dv, pos, vel, acc;
		bit     flip;
		motion_sample_t s;
		t     = 64'(time_point);
		dur   = duration_lsb();
		p0    = longint'($signed(start_position));
		v0    = longint'($signed(start_velocity));
		dv    = longint'($signed(end_velocity)) - v0;
		rem   = t % (2 * dur);
		ang   = $signed((rem << 31) / dur);
		tau_u = (t << 32) / dur;
		tau   = tau_u > (64'd1 << 62) ? (64'sd1 << 62) : $signed(tau_u);
		flip  = 0;
		if (ang >= (64'sd1 << 31))
			ang -= 64'sd1 << 32;
		if (ang > (64'sd1 << 30)) begin
			ang -= 64'sd1 << 31;
			flip = 1;
		end else if (ang < -(64'sd1 << 30)) begin
			ang += 64'sd1 << 31;
			flip = 1;
		end
		x = longint'(GAIN_Q30);
		y = 0;
		for (int i = 0; i < STAGES && i < ATAN_DEPTH; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (ang >= 0) begin
				x -= dx;
				y += dy;
				ang -= longint'(ATAN_TAB[i]);
			end else begin
				x += dx;
				y -= dy;
				ang += longint'(ATAN_TAB[i]);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		k   = scaled_mul(sine_amplitude, $signed(dur), 16);
		k   = scaled_mul(k, longint'(INVPI_Q32), 32);
		pos = p0 + scaled_mul(v0, $signed(t), 16)
			+ scaled_mul(scaled_mul(dv, tau, 16), $signed(t), 33)
			+ scaled_mul(k, (64'sd1 << 30) - x, 30);
		vel = v0 + scaled_mul(dv, tau, 32) + scaled_mul(sine_amplitude, y, 30);
		acc = scaled_mul(dv, inverse_duration, 16)
			+ scaled_mul(scaled_mul(scaled_mul(sine_amplitude, longint'(PI_Q30), 30),
				inverse_duration, 16), x, 30);
		s.position     = 32'(clamp32(pos));
		s.velocity     = 32'(clamp32(vel));
		s.acceleration = 32'(clamp32(acc));
		return s;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_DURATION:  move_duration  = value;
			REG_START_POS: start_position = value;
			REG_END_POS:   end_position   = value;
			REG_START_VEL: start_velocity = value;
			REG_END_VEL:   end_velocity   = value;
			default: ;
		endcase
		if (idx <= REG_END_VEL)
			derive_coefficients();
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);
	endtask

	task automatic set_move(input logic [31:0] dur, input logic [31:0] p0, input logic [31:0] p1,
		input logic [31:0] v0, input logic [31:0] v1);
		write_reg(REG_DURATION, dur);
		write_reg(REG_START_POS, p0);
		write_reg(REG_END_POS, p1);
		write_reg(REG_START_VEL, v0);
		write_reg(REG_END_VEL, v1);
	endtask

	task automatic send_time(input logic [31:0] time_point);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			sample_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		sample_if.valid      <= 1'b1;
		sample_if.time_point <= time_point;
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);
		pending_samples.push_back(predict_motion(time_point));
		beats_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		sample_if.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	always @(negedge clk) begin
		int hold_left;
		if (stall_request > 0) begin
			hold_left = stall_request;
			stall_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		motion_sample_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			beats_checked++;
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat pos=%h vel=%h acc=%h",
						result_if.position, result_if.velocity, result_if.acceleration);
			end else begin
				want = pending_samples.pop_front();
				if (want.position !== result_if.position ||
					want.velocity !== result_if.velocity ||
					want.acceleration !== result_if.acceleration) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: pos %h/%h vel %h/%h acc %h/%h (exp/got)",
							beats_checked, want.position, result_if.position,
							want.velocity, result_if.velocity,
							want.acceleration, result_if.acceleration);
				end
			end
		end
	end

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh0FF_FFFF);
		endcase
	endfunction

	function automatic logic [31:0] rand_duration();
		case ($urandom_range(7))
			0: return $urandom_range(1, 32'h400);
			1: return $urandom;
			2: return $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
			default: return $urandom_range(32'h4000, 32'h8_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_time();
		logic [63:0] span;
		span = 64'(duration_lsb()) * 5 / 2;
		if (span > 64'hFFFF_FFFF)
			span = 64'hFFFF_FFFF;
		if ($urandom_range(9) < 7)
			return $urandom_range(0, 32'(span));
		return $urandom;
	endfunction

	task automatic test_reset_values();
		send_time(32'd0);
		send_time(32'h0001_8000);
		send_time(32'hFFFF_FFFF);
		drain();
	endtask

	task automatic test_phase_points();
		set_move(32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000, 32'h0000_8000, 32'hFFFF_C000);
		send_time(32'd0);
		send_time(32'd1);
		send_time(32'h0000_8000);
		send_time(32'h0001_0000);
		send_time(32'h0001_8000);
		send_time(32'h0002_0000);
		send_time(32'h0002_4000);
		send_time(32'hFFFF_FFFF);
		drain();
	endtask

	task automatic test_tiny_durations();
		set_move(32'd0, 32'h0000_1000, 32'h0000_2000, 32'h0000_0100, 32'h0000_0200);
		send_time(32'd0);
		send_time(32'd1);
		send_time(32'd3);
		send_time(32'hFFFF_FFFF);
		drain();
		write_reg(REG_DURATION, 32'd1);
		send_time(32'd2);
		send_time(32'h5555_5555);
		drain();
	endtask

	task automatic test_saturation();
		set_move(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_time(32'hFFFF_FFFF);
		send_time(32'hAAAA_AAAA);
		drain();
		set_move(32'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_time(32'd1);
		send_time(32'hFFFF_FFFF);
		drain();
	endtask

	task automatic test_spare_index();
		write_reg(REG_SPARE_LO, 32'h1234_5678);
		write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
		send_time(32'h0000_4000);
		send_time(32'h0001_2345);
		drain();
	endtask

	task automatic test_random_moves(input int moves, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int m = 0; m < moves; m++) begin
			set_move(rand_duration(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
			repeat ($urandom_range(80, 120)) send_time(rand_time());
			drain();
		end
	endtask

	task automatic test_output_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_move(32'h0000_C000, rand_q16(), rand_q16(), rand_q16(), rand_q16());
		stall_request = 500;
		repeat (200) send_time(rand_time());
		drain();
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		sample_if.valid      = 1'b0;
		sample_if.time_point = '0;
		result_if.ready      = 1'b0;
		cycles               = 0;
		mismatches           = 0;
		beats_sent           = 0;
		beats_checked        = 0;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		stall_request        = 0;
		move_duration        = 32'h0001_0000;
		start_position       = '0;
		end_position         = '0;
		start_velocity       = '0;
		end_velocity         = '0;
		sine_amplitude       = 0;
		inverse_duration     = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);

		test_reset_values();
		test_phase_points();
		test_tiny_durations();
		test_saturation();
		test_spare_index();
		test_random_moves(5, 17, 79);
		test_random_moves(5, 79, 17);
		test_random_moves(5, 0, 0);
		test_output_stall();

		$display("%0d time beats sent, %0d result beats checked over directed, random",
			beats_sent, beats_checked);
		$display("and stalled moves; %0d mismatches, %0d results outstanding",
			mismatches, pending_samples.size());
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("sinusoidal_trajectory_generator: match");
		else
			$display("sinusoidal_trajectory_generator: mismatch");
		$finish;
	end

endmodule
